### src/slen_pkg.sv
package slen_pkg;

    localparam int DATA_W = 32;
    localparam int CMD_W  = 3;
    localparam int POS_W  = 8;
    localparam int OUT_W  = 7;

    typedef logic [CMD_W-1:0] t_cmd;
    typedef logic [1:0]       t_status;

    localparam t_cmd CMD_INSERT = 3'd0;
    localparam t_cmd CMD_DELETE = 3'd1;
    localparam t_cmd CMD_GET    = 3'd2;
    localparam t_cmd CMD_LOCATE = 3'd3;
    localparam t_cmd CMD_PRED   = 3'd4;
    localparam t_cmd CMD_SUCC   = 3'd5;
    localparam t_cmd CMD_CLEAR  = 3'd6;

    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_BADPOS   = 2'd1;
    localparam t_status ST_NOTFOUND = 2'd2;
    localparam t_status ST_FULL     = 2'd3;

endpackage

### src/sequential_list_engine.sv
// Ordered list of up to DEPTH signed 32-bit elements in a single-port-read,
// single-port-write memory with a length count. One command is taken at a
// time; o_in_ready is low while a command runs and while reset is asserted.
// Every element access goes through the one memory read port, one element
// per cycle, with a single 32-bit equality comparator checking each element
// as it returns. Insert moves the elements from position p up one place
// (none when appending), delete moves those after p down one place, get
// reads one element, and locate / predecessor / successor scan from the
// front. Locate in squared-key mode first has the multiplier square the
// key. A command that ends at once (clear, the unused command, a bad
// position, a full list, a search of an empty list) goes straight to the
// result; o_in_ready rises again as the result is loaded. The result
// is held in an output register, and the block waits only if that register
// is still full when the next result is ready. No clearing pass is needed
// after reset.
module sequential_list_engine #(
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic                                   i_cfg_match_mode,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic [slen_pkg::CMD_W-1:0]             i_command,
    input  logic [slen_pkg::POS_W-1:0]             i_position,
    input  logic signed [slen_pkg::DATA_W-1:0]     i_operand_value,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic [1:0]                             o_status,
    output logic signed [slen_pkg::DATA_W-1:0]     o_result_value,
    output logic [slen_pkg::OUT_W-1:0]             o_found_position,
    output logic [slen_pkg::OUT_W-1:0]             o_list_count,
    output logic                                   o_is_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > 8) ? CW + 1 : 9;
    localparam int DW = slen_pkg::DATA_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQUARE,
        S_SCAN,
        S_SHIFT,
        S_DONE
    } t_state;

    t_state                  r_state;
    slen_pkg::t_cmd          r_cmd;
    logic                    r_mode;
    logic [CW-1:0]           r_count;
    logic [DW-1:0]           r_key;
    logic [CW-1:0]           r_idx;
    logic [CW-1:0]           r_last;
    logic                    r_issue;
    logic                    r_dv;
    logic [CW-1:0]           r_didx;
    logic                    r_first;
    logic                    r_hit;
    logic [DW-1:0]           r_prev;
    slen_pkg::t_status       r_status;
    logic [DW-1:0]           r_result;
    logic [slen_pkg::OUT_W-1:0] r_found;

    logic                    r_out_valid;
    slen_pkg::t_status       r_out_status;
    logic [DW-1:0]           r_out_result;
    logic [slen_pkg::OUT_W-1:0] r_out_found;
    logic [slen_pkg::OUT_W-1:0] r_out_count;
    logic                    r_out_empty;

    logic [DW-1:0]           r_mem [DEPTH];
    logic [DW-1:0]           r_rdata;

    logic                    mem_we;
    logic [AW-1:0]           mem_waddr;
    logic [AW-1:0]           mem_raddr;
    logic [DW-1:0]           mem_wdata;

    logic [XW-1:0]           pos_x;
    logic [XW-1:0]           cnt_x;
    logic [CW-1:0]           pos_m1;
    logic [CW-1:0]           didx_up;
    logic [CW-1:0]           didx_dn;
    logic [XW-1:0]           found_x;
    logic                    key_eq;
    logic                    out_free;

    assign pos_x   = XW'(i_position);
    assign cnt_x   = XW'(r_count);
    assign pos_m1  = CW'(i_position) - CW'(1);
    assign didx_up = r_didx + CW'(1);
    assign didx_dn = r_didx - CW'(1);
    assign found_x = XW'(r_didx) + XW'(1);
    assign key_eq  = (r_rdata == r_key);
    assign out_free = !r_out_valid || i_out_ready;

    assign o_cfg_ready      = i_rst_n;
    assign o_in_ready       = i_rst_n && (r_state == S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out_status;
    assign o_result_value   = r_out_result;
    assign o_found_position = r_out_found;
    assign o_list_count     = r_out_count;
    assign o_is_empty       = r_out_empty;

    // memory port control
    always_comb begin
        mem_raddr = r_idx[AW-1:0];
        mem_we    = 1'b0;
        mem_waddr = didx_dn[AW-1:0];
        mem_wdata = r_rdata;
        if (r_state == S_SHIFT) begin
            if (r_dv) begin
                // move element one place up
                mem_we    = 1'b1;
                mem_waddr = didx_up[AW-1:0];
            end else if (!r_issue) begin
                mem_we    = 1'b1;
                mem_waddr = r_last[AW-1:0];
                mem_wdata = r_key;
            end
        end else if (r_state == S_SCAN && r_cmd == slen_pkg::CMD_DELETE) begin
            // first returned element is the removed one, the rest move down
            mem_we = r_dv && !r_first;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= 1'b0;
            r_count     <= '0;
            r_issue     <= 1'b0;
            r_dv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_mode <= i_cfg_match_mode;
            end
            // a result loaded in S_DONE keeps the register full
            if (r_out_valid && i_out_ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    r_dv <= 1'b0;
                    if (i_in_valid) begin
                        r_cmd    <= i_command;
                        r_key    <= i_operand_value;
                        r_result <= '0;
                        r_found  <= '0;
                        r_first  <= 1'b1;
                        r_hit    <= 1'b0;
                        case (i_command)
                            slen_pkg::CMD_INSERT: begin
                                if (i_position == '0 || pos_x > cnt_x + XW'(1)) begin
                                    r_status <= slen_pkg::ST_BADPOS;
                                    r_state  <= S_DONE;
                                end else if (cnt_x == XW'(DEPTH)) begin
                                    r_status <= slen_pkg::ST_FULL;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_status <= slen_pkg::ST_OK;
                                    r_last   <= pos_m1;
                                    r_idx    <= r_count - CW'(1);
                                    r_issue  <= (pos_x != cnt_x + XW'(1));
                                    r_state  <= S_SHIFT;
                                end
                            end
                            slen_pkg::CMD_DELETE, slen_pkg::CMD_GET: begin
                                if (i_position == '0 || pos_x > cnt_x) begin
                                    r_status <= slen_pkg::ST_BADPOS;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_status <= slen_pkg::ST_OK;
                                    r_idx    <= pos_m1;
                                    r_last   <= (i_command == slen_pkg::CMD_DELETE) ?
                                                r_count - CW'(1) : pos_m1;
                                    r_issue  <= 1'b1;
                                    r_state  <= S_SCAN;
                                end
                            end
                            slen_pkg::CMD_LOCATE, slen_pkg::CMD_PRED,
                            slen_pkg::CMD_SUCC: begin
                                if (r_count == '0) begin
                                    r_status <= slen_pkg::ST_NOTFOUND;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_status <= slen_pkg::ST_OK;
                                    r_idx    <= '0;
                                    r_last   <= r_count - CW'(1);
                                    r_issue  <= 1'b1;
                                    r_state  <= (i_command == slen_pkg::CMD_LOCATE && r_mode) ?
                                                S_SQUARE : S_SCAN;
                                end
                            end
                            slen_pkg::CMD_CLEAR: begin
                                r_status <= slen_pkg::ST_OK;
                                r_count  <= '0;
                                r_state  <= S_DONE;
                            end
                            default: begin
                                r_status <= slen_pkg::ST_OK;
                                r_state  <= S_DONE;
                            end
                        endcase
                    end
                end

                S_SQUARE: begin
                    r_key   <= DW'(r_key * r_key);
                    r_state <= S_SCAN;
                end

                S_SCAN: begin
                    // issue one ascending read per cycle
                    if (r_issue) begin
                        r_dv    <= 1'b1;
                        r_didx  <= r_idx;
                        r_idx   <= r_idx + CW'(1);
                        r_issue <= (r_idx != r_last);
                    end else begin
                        r_dv <= 1'b0;
                    end
                    if (r_dv) begin
                        r_prev <= r_rdata;
                        case (r_cmd)
                            slen_pkg::CMD_GET: begin
                                r_result <= r_rdata;
                                r_state  <= S_DONE;
                            end
                            slen_pkg::CMD_DELETE: begin
                                r_first <= 1'b0;
                                if (r_first) begin
                                    r_result <= r_rdata;
                                end
                                if (!r_issue) begin
                                    r_count <= r_count - CW'(1);
                                    r_state <= S_DONE;
                                end
                            end
                            slen_pkg::CMD_LOCATE: begin
                                if (key_eq) begin
                                    r_found <= found_x[slen_pkg::OUT_W-1:0];
                                    r_state <= S_DONE;
                                end else if (!r_issue) begin
                                    r_status <= slen_pkg::ST_NOTFOUND;
                                    r_state  <= S_DONE;
                                end
                            end
                            slen_pkg::CMD_PRED: begin
                                if (r_didx != '0 && key_eq) begin
                                    r_result <= r_prev;
                                    r_state  <= S_DONE;
                                end else if (!r_issue) begin
                                    r_status <= slen_pkg::ST_NOTFOUND;
                                    r_state  <= S_DONE;
                                end
                            end
                            slen_pkg::CMD_SUCC: begin
                                // a hit takes the element that arrives next
                                if (r_hit) begin
                                    r_result <= r_rdata;
                                    r_state  <= S_DONE;
                                end else if (key_eq && r_didx != r_last) begin
                                    r_hit <= 1'b1;
                                end else if (!r_issue) begin
                                    r_status <= slen_pkg::ST_NOTFOUND;
                                    r_state  <= S_DONE;
                                end
                            end
                            default: begin
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end

                S_SHIFT: begin
                    // descending reads, each written one place up in the cycle after its read
                    if (r_issue) begin
                        r_dv    <= 1'b1;
                        r_didx  <= r_idx;
                        r_idx   <= r_idx - CW'(1);
                        r_issue <= (r_idx != r_last);
                    end else begin
                        r_dv <= 1'b0;
                        if (!r_dv) begin
                            r_count <= r_count + CW'(1);
                            r_state <= S_DONE;
                        end
                    end
                end

                S_DONE: begin
                    r_dv    <= 1'b0;
                    r_issue <= 1'b0;
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_status;
                        r_out_result <= r_result;
                        r_out_found  <= r_found;
                        r_out_count  <= cnt_x[slen_pkg::OUT_W-1:0];
                        r_out_empty  <= (r_count == '0);
                        r_state      <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
